### design/hed_pkg.sv
// ---------------------------------------------------------------------------
// hed_pkg: shared types and constants for the markup strip / entity decoder
// Entity name table, character codes and the result-run record.
// ---------------------------------------------------------------------------
`default_nettype none

package hed_pkg;

   localparam int ENTITY_MAX_DEF = 7;
   localparam int MAX_RESULTS    = 8;
   localparam int RUN_CNT_W      = $clog2(MAX_RESULTS + 1);
   localparam int NAME_CAP       = 7;
   localparam int TABLE_SIZE     = 30;

   localparam logic [7:0] CH_NUL  = 8'h00;
   localparam logic [7:0] CH_LF   = 8'h0A;
   localparam logic [7:0] CH_AMP  = 8'h26;
   localparam logic [7:0] CH_SEMI = 8'h3B;
   localparam logic [7:0] CH_LT   = 8'h3C;
   localparam logic [7:0] CH_GT   = 8'h3E;

   // bytes of one item's output run, slot 0 goes out first
   typedef struct packed {
      logic [MAX_RESULTS-1:0][7:0] bytes;
      logic [RUN_CNT_W-1:0]        len;
   } run_type;

   // name is right-aligned: first character in the highest used byte
   typedef struct packed {
      logic [8*NAME_CAP-1:0] name;
      logic [3:0]            name_len;
      logic [15:0]           rep;
      logic [1:0]            rep_len;
   } ent_type;

   localparam ent_type ENT_TAB [TABLE_SIZE] = '{
      '{"gt;",     4'd3, {">", 8'h00}, 2'd1},
      '{"lt;",     4'd3, {"<", 8'h00}, 2'd1},
      '{"nbsp;",   4'd5, {" ", 8'h00}, 2'd1},
      '{"amp;",    4'd4, {"&", 8'h00}, 2'd1},
      '{"eacute;", 4'd7, {"e", 8'h00}, 2'd1},
      '{"egrave;", 4'd7, {"e", 8'h00}, 2'd1},
      '{"uacute;", 4'd7, {"u", 8'h00}, 2'd1},
      '{"ugrave;", 4'd7, {"u", 8'h00}, 2'd1},
      '{"Uacute;", 4'd7, {"U", 8'h00}, 2'd1},
      '{"Ugrave;", 4'd7, {"U", 8'h00}, 2'd1},
      '{"iacute;", 4'd7, {"i", 8'h00}, 2'd1},
      '{"iuml;",   4'd5, {"i", 8'h00}, 2'd1},
      '{"igrave;", 4'd7, {"i", 8'h00}, 2'd1},
      '{"Iacute;", 4'd7, {"I", 8'h00}, 2'd1},
      '{"Igrave;", 4'd7, {"I", 8'h00}, 2'd1},
      '{"aacute;", 4'd7, {"a", 8'h00}, 2'd1},
      '{"agrave;", 4'd7, {"a", 8'h00}, 2'd1},
      '{"oacute;", 4'd7, {"o", 8'h00}, 2'd1},
      '{"ograve;", 4'd7, {"o", 8'h00}, 2'd1},
      '{"ouml;",   4'd5, {"o", "e"},   2'd2},
      '{"Eacute;", 4'd7, {"E", 8'h00}, 2'd1},
      '{"Egrave;", 4'd7, {"E", 8'h00}, 2'd1},
      '{"Aacute;", 4'd7, {"A", 8'h00}, 2'd1},
      '{"Agrave;", 4'd7, {"A", 8'h00}, 2'd1},
      '{"Auml;",   4'd5, {"A", "e"},   2'd2},
      '{"Oacute;", 4'd7, {"O", 8'h00}, 2'd1},
      '{"Ograve;", 4'd7, {"O", 8'h00}, 2'd1},
      '{"Ouml;",   4'd5, {"O", "e"},   2'd2},
      '{"Uuml;",   4'd5, {"U", "e"},   2'd2},
      '{"quot;",   4'd5, {"\"", 8'h00}, 2'd1}
   };

   // character k (from 0) of a table name; only valid for k < name_len
   function automatic logic [7:0] ent_char(input ent_type e, input int k);
      int pos;
      pos = int'(e.name_len) - 1 - k;
      if (pos < 0) begin
         return CH_NUL;
      end
      return e.name[8*pos +: 8];
   endfunction

endpackage

`default_nettype wire

### design/hed_req_if.sv
// ---------------------------------------------------------------------------
// hed_req_if: input byte channel
// Valid/ready channel carrying one text byte and the end-of-stream mark.
// ---------------------------------------------------------------------------
`default_nettype none

interface hed_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_stream;

   modport source (output valid, output in_byte, output end_of_stream, input ready);
   modport sink   (input valid, input in_byte, input end_of_stream, output ready);
endinterface

`default_nettype wire

### design/hed_rsp_if.sv
// ---------------------------------------------------------------------------
// hed_rsp_if: output byte channel
// Valid/ready channel carrying one emitted byte and its end-of-run flag.
// ---------------------------------------------------------------------------
`default_nettype none

interface hed_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last_of_run;

   modport source (output valid, output out_byte, output last_of_run, input ready);
   modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

`default_nettype wire

### design/html_strip_entity_decode_top.sv
// ---------------------------------------------------------------------------
// html_strip_entity_decode_top: markup strip and named entity decoder
// Output: results of an item are presented in the cycle after its transfer.
// Throughput: one input byte per cycle when it yields at most one result and
//   the output port is ready; an item yielding more holds the input until its last byte leaves.
// Reset: synchronous, clears parse mode, entity count, newline flag and the
//   output run; the entity buffer is left as is.
// ---------------------------------------------------------------------------
`default_nettype none

module html_strip_entity_decode_top #(
   parameter int ENTITY_MAX = hed_pkg::ENTITY_MAX_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   hed_req_if.sink   req_if,
   hed_rsp_if.source rsp_if
);
   import hed_pkg::*;

   // Flow:
   //  - hed_decode looks at the offered byte and the parse state and builds
   //    the whole run of output bytes (0 to MAX_RESULTS) for it.
   //  - On transfer the run is loaded into a shift register; the state in
   //    hed_decode advances in the same cycle.
   //  - The run drains one byte per cycle while the output is ready, slot 0
   //    first; last_of_run marks the final byte. Items that emit nothing load an empty run.
   //  - A new byte is taken when the register is empty or its final byte
   //    leaves in this cycle, so single-byte runs stream back to back.

   run_type                     run;
   logic [MAX_RESULTS-1:0][7:0] bytes_ff, bytes_in;
   logic [RUN_CNT_W-1:0]        rem_ff, rem_in;
   logic                        req_accept;
   logic                        rsp_accept;

   assign req_if.ready = (rem_ff == '0) || (rem_ff == RUN_CNT_W'(1) && rsp_if.ready);
   assign req_accept   = req_if.valid && req_if.ready;
   assign rsp_accept   = rsp_if.valid && rsp_if.ready;

   hed_decode #(
      .ENTITY_MAX (ENTITY_MAX)
   ) u_decode (
      .clock         (clock),
      .reset         (reset),
      .accept        (req_accept),
      .in_byte       (req_if.in_byte),
      .end_of_stream (req_if.end_of_stream),
      .run           (run)
   );

   // output run: load on input transfer, else shift on output transfer
   always_comb begin
      bytes_in = bytes_ff;
      rem_in   = rem_ff;
      if (req_accept) begin
         bytes_in = run.bytes;
         rem_in   = run.len;
      end else if (rsp_accept) begin
         for (int i = 0; i < MAX_RESULTS - 1; i++) begin
            bytes_in[i] = bytes_ff[i+1];
         end
         bytes_in[MAX_RESULTS-1] = CH_NUL;
         rem_in = rem_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      bytes_ff <= bytes_in;
      if (reset) begin
         rem_ff <= '0;
      end else begin
         rem_ff <= rem_in;
      end
   end

   assign rsp_if.valid       = (rem_ff != '0);
   assign rsp_if.out_byte    = bytes_ff[0];
   assign rsp_if.last_of_run = (rem_ff == RUN_CNT_W'(1));

endmodule

`default_nettype wire

### design/hed_decode.sv
// ---------------------------------------------------------------------------
// hed_decode: parse state and per-byte run builder
// Holds mode, entity buffer and newline flag; builds the output run of the
// byte presented and advances state when that byte is taken.
// ---------------------------------------------------------------------------
`default_nettype none

module hed_decode #(
   parameter int ENTITY_MAX = hed_pkg::ENTITY_MAX_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             accept,
   input  wire logic [7:0]       in_byte,
   input  wire logic             end_of_stream,
   output hed_pkg::run_type      run
);
   import hed_pkg::*;

   localparam int CNT_W = $clog2(ENTITY_MAX + 1);

   typedef enum logic [1:0] {
      MODE_TEXT   = 2'd0,
      MODE_TAG    = 2'd1,
      MODE_ENTITY = 2'd2
   } mode_type;

   mode_type              mode_ff, mode_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  lwn_ff, lwn_in;
   logic [7:0]            buf_ff [ENTITY_MAX];
   logic                  buf_we;

   logic [7:0]            buf_app [ENTITY_MAX];
   logic [CNT_W-1:0]      cnt1;
   logic [CNT_W-1:0]      raw_cnt;
   logic [CNT_W:0]        raw_sum;
   run_type               raw_run;
   logic                  hit;
   logic [15:0]           hit_rep;
   logic [1:0]            hit_len;
   logic                  name_ok;
   run_type               run_c;
   logic [7:0]            last_byte;

   // buffer as it looks with the current byte appended
   always_comb begin
      for (int k = 0; k < ENTITY_MAX; k++) begin
         buf_app[k] = (int'(cnt_ff) == k) ? in_byte : buf_ff[k];
      end
   end

   assign cnt1 = cnt_ff + 1'b1;

   // table match on ';' (name lengths include the ';')
   always_comb begin
      hit     = 1'b0;
      hit_rep = '0;
      hit_len = '0;
      for (int t = 0; t < TABLE_SIZE; t++) begin
         name_ok = (int'(cnt1) == int'(ENT_TAB[t].name_len));
         for (int k = 0; k < NAME_CAP - 1; k++) begin
            if (k < int'(ENT_TAB[t].name_len) - 1 && buf_ff[k] != ent_char(ENT_TAB[t], k)) begin
               name_ok = 1'b0;
            end
         end
         if (name_ok && !hit) begin
            hit     = 1'b1;
            hit_rep = ENT_TAB[t].rep;
            hit_len = ENT_TAB[t].rep_len;
         end
      end
   end

   // raw echo: '&' then buffered bytes, clipped to the run size
   always_comb begin
      raw_cnt = (mode_ff == MODE_ENTITY && !end_of_stream && in_byte != CH_NUL) ? cnt1 : cnt_ff;
      raw_sum = {1'b0, raw_cnt} + 1'b1;
      raw_run.bytes[0] = CH_AMP;
      for (int k = 0; k < MAX_RESULTS - 1; k++) begin
         raw_run.bytes[k+1] = buf_app[k];
      end
      if (int'(raw_sum) > MAX_RESULTS) begin
         raw_run.len = RUN_CNT_W'(MAX_RESULTS);
      end else begin
         raw_run.len = RUN_CNT_W'(raw_sum);
      end
   end

   always_comb begin
      mode_in   = mode_ff;
      cnt_in    = cnt_ff;
      buf_we    = 1'b0;
      run_c     = '0;
      last_byte = CH_NUL;

      if (end_of_stream) begin
         if (mode_ff == MODE_ENTITY) begin
            run_c = raw_run;
         end
         mode_in = MODE_TEXT;
         cnt_in  = '0;
      end else begin
         case (mode_ff)
            MODE_TAG: begin
               if (in_byte == CH_GT) begin
                  mode_in = MODE_TEXT;
               end
            end
            MODE_ENTITY: begin
               if (in_byte == CH_NUL) begin
                  run_c   = raw_run;
                  mode_in = MODE_TEXT;
                  cnt_in  = '0;
               end else begin
                  buf_we = 1'b1;
                  if (in_byte == CH_SEMI) begin
                     if (hit) begin
                        run_c.bytes[0] = hit_rep[15:8];
                        run_c.bytes[1] = hit_rep[7:0];
                        run_c.len      = RUN_CNT_W'(hit_len);
                     end else begin
                        run_c = raw_run;
                     end
                     mode_in = MODE_TEXT;
                     cnt_in  = '0;
                  end else if (int'(cnt1) == ENTITY_MAX) begin
                     run_c   = raw_run;
                     mode_in = MODE_TEXT;
                     cnt_in  = '0;
                  end else begin
                     cnt_in = cnt1;
                  end
               end
            end
            default: begin
               mode_in = MODE_TEXT;
               if (in_byte == CH_LT) begin
                  mode_in = MODE_TAG;
               end else if (in_byte == CH_AMP) begin
                  mode_in = MODE_ENTITY;
                  cnt_in  = '0;
               end else begin
                  run_c.bytes[0] = in_byte;
                  run_c.len      = RUN_CNT_W'(1);
               end
            end
         endcase
      end

      for (int i = 0; i < MAX_RESULTS; i++) begin
         if (int'(run_c.len) == i + 1) begin
            last_byte = run_c.bytes[i];
         end
      end
      lwn_in = (run_c.len != '0) ? (last_byte == CH_LF) : lwn_ff;

      // closing newline unless the output already ends in one, dropped if the run is already full
      if (end_of_stream) begin
         if (!lwn_in && int'(run_c.len) < MAX_RESULTS) begin
            for (int i = 0; i < MAX_RESULTS; i++) begin
               if (int'(run_c.len) == i) begin
                  run_c.bytes[i] = CH_LF;
               end
            end
            run_c.len = run_c.len + 1'b1;
         end
         lwn_in = 1'b0;
      end
   end

   assign run = run_c;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_TEXT;
         cnt_ff  <= '0;
         lwn_ff  <= 1'b0;
      end else if (accept) begin
         mode_ff <= mode_in;
         cnt_ff  <= cnt_in;
         lwn_ff  <= lwn_in;
      end
      if (accept && buf_we) begin
         for (int k = 0; k < ENTITY_MAX; k++) begin
            if (int'(cnt_ff) == k) begin
               buf_ff[k] <= in_byte;
            end
         end
      end
   end

endmodule

`default_nettype wire
